### hw/rtl/bcm_pkg.sv
`default_nettype none
package bcm_pkg;
    localparam int FifoDepth = 16;
    localparam int Waiters = 8;
    localparam int FifoAw = $clog2(FifoDepth);
    localparam int WaitAw = $clog2(Waiters);

    typedef enum logic [2:0] {
        OP_SEND_B = 3'd0,
        OP_SEND_NB = 3'd1,
        OP_RECV_B = 3'd2,
        OP_RECV_NB = 3'd3,
        OP_CLOSE = 3'd4
    } op_t;

    localparam logic [3:0] ST_SENT = 4'd0;
    localparam logic [3:0] ST_SEND_WAIT = 4'd1;
    localparam logic [3:0] ST_SEND_BLOCK = 4'd2;
    localparam logic [3:0] ST_SEND_CLOSED = 4'd3;
    localparam logic [3:0] ST_RECEIVED = 4'd4;
    localparam logic [3:0] ST_RECV_WAIT = 4'd5;
    localparam logic [3:0] ST_RECV_EMPTY = 4'd6;
    localparam logic [3:0] ST_RECV_CLOSED = 4'd7;
    localparam logic [3:0] ST_CLOSED_OK = 4'd8;
    localparam logic [3:0] ST_CLOSE_TWICE = 4'd9;
    localparam logic [3:0] ST_SNDR_DONE = 4'd10;
    localparam logic [3:0] ST_SNDR_ABORT = 4'd11;
    localparam logic [3:0] ST_RCVR_CLOSED = 4'd12;
    localparam logic [3:0] ST_QUEUE_FULL = 4'd13;

    typedef struct packed {
        logic [2:0] operation;
        logic [3:0] requester;
        logic [31:0] payload;
    } req_t;

    typedef struct packed {
        logic [3:0] client;
        logic [3:0] status;
        logic [31:0] data_out;
        logic last;
    } cpl_t;
endpackage
`default_nettype wire

### hw/rtl/bcm_ram.sv
`default_nettype none
module bcm_ram #(
    parameter int Depth = 16,
    parameter int Width = 32
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [$clog2(Depth)-1:0] waddr,
    input wire logic [Width-1:0] wdata,
    input wire logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0] rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/blocking_channel_mailbox_unit.sv
// Send/receive results are registered through S_READ and S_EXEC after the accepting edge;
//   a second result, when there is one, follows in the next cycle. Close results come from
//   S_CLOSE, which alternates reading a waiter queue head and emitting a result. busy drops
//   as the last result of a request is strobed. Queue memories have a registered read.
// Reset (rst_n low, async) empties queues, opens the channel, capacity 0.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
module blocking_channel_mailbox_unit
    import bcm_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    output logic busy,
    input wire req_t request,
    input wire logic cfg_valid,
    output logic cfg_ready,
    input wire logic [4:0] cfg_data,
    output logic result_valid,
    output cpl_t result
);
    typedef enum logic [1:0] { S_IDLE, S_READ, S_EXEC, S_CLOSE } state_t;

    state_t state_reg;
    req_t req_reg;
    logic [4:0] cap_reg;
    logic [FifoAw-1:0] fhead_reg;
    logic [FifoAw:0] fcount_reg;
    logic closed_reg;
    logic [WaitAw-1:0] sh_reg, st_reg, rh_reg, rt_reg;
    logic [WaitAw:0] scnt_reg, rcnt_reg;
    logic ph2_reg;
    logic pend_reg;
    cpl_t pend_cpl_reg;
    logic result_valid_reg;
    cpl_t result_reg;

    logic f_we, s_we, r_we;
    logic [FifoAw-1:0] f_waddr, f_raddr;
    logic [31:0] f_wdata, f_rdata, sd_rdata, sd_wdata;
    logic [3:0] sid_rdata, rid_rdata, sid_wdata;
    logic [WaitAw-1:0] s_raddr, r_raddr;

    bcm_ram #(.Depth(FifoDepth), .Width(32)) u_fifo (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata));
    bcm_ram #(.Depth(Waiters), .Width(36)) u_sq (
        .clk(clk), .we(s_we), .waddr(st_reg), .wdata({sid_wdata, sd_wdata}),
        .raddr(s_raddr), .rdata({sid_rdata, sd_rdata}));
    bcm_ram #(.Depth(Waiters), .Width(4)) u_rq (
        .clk(clk), .we(r_we), .waddr(rt_reg), .wdata(req_reg.requester),
        .raddr(r_raddr), .rdata(rid_rdata));

    logic [4:0] cap_eff;
    assign cap_eff = (cap_reg > 5'(FifoDepth)) ? 5'(FifoDepth) : cap_reg;
    logic cap0, fempty, froom;
    assign cap0 = (cap_eff == 5'd0);
    assign fempty = (fcount_reg == '0);
    assign froom = ({1'b0, fcount_reg} < 6'(cap_eff));

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    assign f_raddr = fhead_reg;
    assign s_raddr = sh_reg;
    assign r_raddr = rh_reg;
    assign sid_wdata = req_reg.requester;
    assign sd_wdata = req_reg.payload;

    logic is_send, is_recv, blk;
    assign is_send = (req_reg.operation == OP_SEND_B) || (req_reg.operation == OP_SEND_NB);
    assign is_recv = (req_reg.operation == OP_RECV_B) || (req_reg.operation == OP_RECV_NB);
    assign blk = (req_reg.operation == OP_SEND_B) || (req_reg.operation == OP_RECV_B);

    // exec decode
    logic x_send_rcv, x_send_push, x_send_wait, x_recv_snd, x_recv_take_sd, x_recv_pop;
    logic x_recv_wait;
    always_comb
    begin
        x_send_rcv = is_send && !closed_reg && rcnt_reg != '0;
        x_send_push = is_send && !closed_reg && rcnt_reg == '0 && froom;
        x_send_wait = is_send && !closed_reg && rcnt_reg == '0 && !froom && blk
                      && scnt_reg != (WaitAw+1)'(Waiters);
        x_recv_snd = is_recv && !(closed_reg && fempty)
                     && !(!blk && ((cap0 && scnt_reg == '0) || (!cap0 && fempty)))
                     && scnt_reg != '0;
        x_recv_take_sd = x_recv_snd && (cap0 || fempty);
        x_recv_pop = is_recv && !(closed_reg && fempty)
                     && !(!blk && ((cap0 && scnt_reg == '0) || (!cap0 && fempty)))
                     && ((scnt_reg != '0 && !x_recv_take_sd) || (scnt_reg == '0 && !fempty));
        x_recv_wait = is_recv && !closed_reg && fempty && blk && scnt_reg == '0
                      && rcnt_reg != (WaitAw+1)'(Waiters);
    end

    logic exec;
    assign exec = (state_reg == S_EXEC) && !pend_reg;
    assign s_we = exec && x_send_wait;
    assign r_we = exec && x_recv_wait;
    always_comb
    begin
        f_we = 1'b0;
        f_waddr = FifoAw'(fhead_reg + fcount_reg[FifoAw-1:0]);
        f_wdata = req_reg.payload;
        if (exec && x_send_push)
        begin
            f_we = 1'b1;
        end
        else if (exec && x_recv_snd && !x_recv_take_sd)
        begin
            f_we = 1'b1;
            f_wdata = sd_rdata;
        end
    end

    function automatic cpl_t mk(logic [3:0] c, logic [3:0] s, logic [31:0] d, logic l);
        cpl_t r;
        r.client = c;
        r.status = s;
        r.data_out = d;
        r.last = l;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            req_reg <= '0;
            cap_reg <= '0;
            fhead_reg <= '0;
            fcount_reg <= '0;
            closed_reg <= 1'b0;
            sh_reg <= '0;
            st_reg <= '0;
            rh_reg <= '0;
            rt_reg <= '0;
            scnt_reg <= '0;
            rcnt_reg <= '0;
            ph2_reg <= 1'b0;
            pend_reg <= 1'b0;
            pend_cpl_reg <= '0;
            result_valid_reg <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        cap_reg <= cfg_data;
                    end
                    if (start)
                    begin
                        req_reg <= request;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    // memory reads for head entries land now
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    result_valid_reg <= 1'b1;
                    pend_reg <= 1'b0;
                    if (pend_reg)
                    begin
                        result_reg <= pend_cpl_reg;
                    end
                    else if (is_send)
                    begin
                        if (closed_reg)
                        begin
                            result_reg <= mk(req_reg.requester, ST_SEND_CLOSED, '0, 1'b1);
                        end
                        else if (x_send_rcv)
                        begin
                            result_reg <= mk(rid_rdata, ST_RECEIVED, req_reg.payload, 1'b0);
                            pend_reg <= 1'b1;
                            pend_cpl_reg <= mk(req_reg.requester, ST_SENT, '0, 1'b1);
                            state_reg <= S_EXEC;
                            rh_reg <= WaitAw'(rh_reg + 1'b1);
                            rcnt_reg <= rcnt_reg - 1'b1;
                        end
                        else if (x_send_push)
                        begin
                            result_reg <= mk(req_reg.requester, ST_SENT, '0, 1'b1);
                            fcount_reg <= fcount_reg + 1'b1;
                        end
                        else if (!blk)
                        begin
                            result_reg <= mk(req_reg.requester, ST_SEND_BLOCK, '0, 1'b1);
                        end
                        else if (!x_send_wait)
                        begin
                            result_reg <= mk(req_reg.requester, ST_QUEUE_FULL, '0, 1'b1);
                        end
                        else
                        begin
                            result_reg <= mk(req_reg.requester, ST_SEND_WAIT, '0, 1'b1);
                            st_reg <= WaitAw'(st_reg + 1'b1);
                            scnt_reg <= scnt_reg + 1'b1;
                        end
                    end
                    else if (is_recv)
                    begin
                        if (closed_reg && fempty)
                        begin
                            result_reg <= mk(req_reg.requester, ST_RECV_CLOSED, '0, 1'b1);
                        end
                        else if (!blk && ((cap0 && scnt_reg == '0) || (!cap0 && fempty)))
                        begin
                            result_reg <= mk(req_reg.requester, ST_RECV_EMPTY, '0, 1'b1);
                        end
                        else if (x_recv_snd)
                        begin
                            result_reg <= mk(sid_rdata, ST_SNDR_DONE, '0, 1'b0);
                            pend_reg <= 1'b1;
                            pend_cpl_reg <= mk(req_reg.requester, ST_RECEIVED,
                                               x_recv_take_sd ? sd_rdata : f_rdata, 1'b1);
                            state_reg <= S_EXEC;
                            sh_reg <= WaitAw'(sh_reg + 1'b1);
                            scnt_reg <= scnt_reg - 1'b1;
                            if (!x_recv_take_sd)
                            begin
                                fhead_reg <= FifoAw'(fhead_reg + 1'b1);
                            end
                        end
                        else if (x_recv_pop)
                        begin
                            result_reg <= mk(req_reg.requester, ST_RECEIVED, f_rdata, 1'b1);
                            fhead_reg <= FifoAw'(fhead_reg + 1'b1);
                            fcount_reg <= fcount_reg - 1'b1;
                        end
                        else if (!blk)
                        begin
                            result_reg <= mk(req_reg.requester, ST_RECV_EMPTY, '0, 1'b1);
                        end
                        else if (!x_recv_wait)
                        begin
                            result_reg <= mk(req_reg.requester, ST_QUEUE_FULL, '0, 1'b1);
                        end
                        else
                        begin
                            result_reg <= mk(req_reg.requester, ST_RECV_WAIT, '0, 1'b1);
                            rt_reg <= WaitAw'(rt_reg + 1'b1);
                            rcnt_reg <= rcnt_reg + 1'b1;
                        end
                    end
                    else if (req_reg.operation == OP_CLOSE)
                    begin
                        if (closed_reg)
                        begin
                            result_reg <= mk(req_reg.requester, ST_CLOSE_TWICE, '0, 1'b1);
                        end
                        else
                        begin
                            closed_reg <= 1'b1;
                            result_valid_reg <= 1'b0;
                            ph2_reg <= 1'b0;
                            state_reg <= S_CLOSE;
                        end
                    end
                    else
                    begin
                        result_valid_reg <= 1'b0;
                    end
                end
                S_CLOSE:
                begin
                    // memory read addressed by head registers is registered, so a moved head's
                    // entry is not valid at once; alternate read and emit
                    ph2_reg <= !ph2_reg;
                    if (ph2_reg)
                    begin
                        result_valid_reg <= 1'b1;
                        if (rcnt_reg != '0)
                        begin
                            result_reg <= mk(rid_rdata, ST_RCVR_CLOSED, '0, 1'b0);
                            rh_reg <= WaitAw'(rh_reg + 1'b1);
                            rcnt_reg <= rcnt_reg - 1'b1;
                        end
                        else if (scnt_reg != '0)
                        begin
                            result_reg <= mk(sid_rdata, ST_SNDR_ABORT, '0, 1'b0);
                            sh_reg <= WaitAw'(sh_reg + 1'b1);
                            scnt_reg <= scnt_reg - 1'b1;
                        end
                        else
                        begin
                            result_reg <= mk(req_reg.requester, ST_CLOSED_OK, '0, 1'b1);
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### dv/tb.sv
`default_nettype none
module tb;
    import bcm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t request = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [4:0] cfg_data = '0;
    logic result_valid;
    cpl_t result;

    blocking_channel_mailbox_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .result(result)
    );

    always #5 clk = ~clk;

    // channel state mirror
    logic [4:0] cap_reg;
    logic [31:0] fifo_mem [FifoDepth];
    logic [3:0] fifo_rd;
    logic [4:0] fifo_fill;
    logic chan_closed;
    logic [3:0] snd_ids [Waiters];
    logic [31:0] snd_words [Waiters];
    logic [3:0] rcv_ids [Waiters];
    logic [2:0] snd_rd, snd_wr, rcv_rd, rcv_wr;
    int snd_cnt, rcv_cnt;

    cpl_t pending_cpl [$];
    int errors = 0;
    int idle_cycles = 0;

    function automatic cpl_t mk(logic [3:0] who, logic [3:0] st, logic [31:0] d, logic fin);
        cpl_t c;
        c.client = who;
        c.status = st;
        c.data_out = d;
        c.last = fin;
        return c;
    endfunction

    function automatic int usable_slots();
        return (cap_reg > FifoDepth) ? FifoDepth : int'(cap_reg);
    endfunction

    function automatic logic [31:0] fifo_take();
        logic [31:0] v;
        v = fifo_mem[fifo_rd];
        fifo_rd = fifo_rd + 1'b1;
        fifo_fill = fifo_fill - 1'b1;
        return v;
    endfunction

    function automatic void fifo_put(logic [31:0] v);
        fifo_mem[4'(fifo_rd + fifo_fill)] = v;
        fifo_fill = fifo_fill + 1'b1;
    endfunction

    function automatic void predict_send(logic [3:0] who, logic [31:0] d, logic blk);
        if (chan_closed) begin
            pending_cpl.push_back(mk(who, ST_SEND_CLOSED, '0, 1'b1));
        end else if (rcv_cnt > 0) begin
            pending_cpl.push_back(mk(rcv_ids[rcv_rd], ST_RECEIVED, d, 1'b0));
            rcv_rd++;
            rcv_cnt--;
            pending_cpl.push_back(mk(who, ST_SENT, '0, 1'b1));
        end else if (int'(fifo_fill) < usable_slots()) begin
            fifo_put(d);
            pending_cpl.push_back(mk(who, ST_SENT, '0, 1'b1));
        end else if (!blk) begin
            pending_cpl.push_back(mk(who, ST_SEND_BLOCK, '0, 1'b1));
        end else if (snd_cnt >= Waiters) begin
            pending_cpl.push_back(mk(who, ST_QUEUE_FULL, '0, 1'b1));
        end else begin
            snd_ids[snd_wr] = who;
            snd_words[snd_wr] = d;
            snd_wr++;
            snd_cnt++;
            pending_cpl.push_back(mk(who, ST_SEND_WAIT, '0, 1'b1));
        end
    endfunction

    function automatic void predict_recv(logic [3:0] who, logic blk);
        int slots;
        logic [31:0] got;
        slots = usable_slots();
        if (chan_closed && fifo_fill == 0) begin
            pending_cpl.push_back(mk(who, ST_RECV_CLOSED, '0, 1'b1));
        end else if (!blk && ((slots == 0 && snd_cnt == 0) || (slots > 0 && fifo_fill == 0)))
        begin
            pending_cpl.push_back(mk(who, ST_RECV_EMPTY, '0, 1'b1));
        end else if (snd_cnt > 0) begin
            if (slots == 0 || fifo_fill == 0) begin
                got = snd_words[snd_rd];
            end else begin
                got = fifo_take();
                fifo_put(snd_words[snd_rd]);
            end
            pending_cpl.push_back(mk(snd_ids[snd_rd], ST_SNDR_DONE, '0, 1'b0));
            pending_cpl.push_back(mk(who, ST_RECEIVED, got, 1'b1));
            snd_rd++;
            snd_cnt--;
        end else if (fifo_fill > 0) begin
            pending_cpl.push_back(mk(who, ST_RECEIVED, fifo_take(), 1'b1));
        end else if (!blk) begin
            pending_cpl.push_back(mk(who, ST_RECV_EMPTY, '0, 1'b1));
        end else if (rcv_cnt >= Waiters) begin
            pending_cpl.push_back(mk(who, ST_QUEUE_FULL, '0, 1'b1));
        end else begin
            rcv_ids[rcv_wr] = who;
            rcv_wr++;
            rcv_cnt++;
            pending_cpl.push_back(mk(who, ST_RECV_WAIT, '0, 1'b1));
        end
    endfunction

    function automatic void predict_close(logic [3:0] who);
        if (chan_closed) begin
            pending_cpl.push_back(mk(who, ST_CLOSE_TWICE, '0, 1'b1));
            return;
        end
        chan_closed = 1'b1;
        while (rcv_cnt > 0) begin
            pending_cpl.push_back(mk(rcv_ids[rcv_rd], ST_RCVR_CLOSED, '0, 1'b0));
            rcv_rd++;
            rcv_cnt--;
        end
        while (snd_cnt > 0) begin
            pending_cpl.push_back(mk(snd_ids[snd_rd], ST_SNDR_ABORT, '0, 1'b0));
            snd_rd++;
            snd_cnt--;
        end
        pending_cpl.push_back(mk(who, ST_CLOSED_OK, '0, 1'b1));
    endfunction

    function automatic void predict_request(req_t r);
        case (r.operation)
            OP_SEND_B: predict_send(r.requester, r.payload, 1'b1);
            OP_SEND_NB: predict_send(r.requester, r.payload, 1'b0);
            OP_RECV_B: predict_recv(r.requester, 1'b1);
            OP_RECV_NB: predict_recv(r.requester, 1'b0);
            OP_CLOSE: predict_close(r.requester);
            default: ;
        endcase
    endfunction

    // checker
    always @(posedge clk) begin
        cpl_t exp_c;
        if (rst_n && result_valid) begin
            if (pending_cpl.size() == 0) begin
                $display("%0t: unexpected completion, expected none, actual %h", $time,
                    result);
                errors++;
            end else begin
                exp_c = pending_cpl.pop_front();
                if (result.client !== exp_c.client) begin
                    $display("%0t: client mismatch, expected %0d, actual %0d", $time,
                        exp_c.client, result.client);
                    errors++;
                end
                if (result.status !== exp_c.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                        exp_c.status, result.status);
                    errors++;
                end
                if (result.data_out !== exp_c.data_out) begin
                    $display("%0t: data_out mismatch, expected %h, actual %h", $time,
                        exp_c.data_out, result.data_out);
                    errors++;
                end
                if (result.last !== exp_c.last) begin
                    $display("%0t: last mismatch, expected %0d, actual %0d", $time,
                        exp_c.last, result.last);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("** blocking_channel_mailbox_unit: FAILED **");
            $finish;
        end
    end

    task automatic issue(op_t op, logic [3:0] who, logic [31:0] d, bit gaps = 1'b1);
        int gap;
        req_t r;
        gap = gaps ? $urandom_range(0, 8) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        // the block is still busy after an accept, so this edge costs nothing
        @(posedge clk);
        repeat (gap) @(posedge clk);
        r.operation = op;
        r.requester = who;
        r.payload = d;
        start <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        predict_request(r);
        start <= 1'b0;
    endtask

    task automatic drain();
        while (pending_cpl.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_capacity(logic [4:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cap_reg = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // reopening a closed channel is only possible by reset, so close once at the end
    task automatic test_rendezvous();
        write_capacity(5'd0);
        issue(OP_RECV_NB, 4'd0, '0);
        issue(OP_SEND_NB, 4'd15, 32'hFFFF_FFFF);
        issue(OP_RECV_B, 4'd1, '0);
        issue(OP_SEND_B, 4'd2, 32'hFFFF_FFFF);
        issue(OP_SEND_B, 4'd3, 32'h0000_0000);
        issue(OP_RECV_NB, 4'd4, '0);
        for (int i = 0; i < 9; i++)
            issue(OP_SEND_B, 4'(i), 32'hA5A5_0000 + i);
        for (int i = 0; i < 9; i++)
            issue(OP_RECV_B, 4'(i + 5), '0);
        issue(op_t'(3'd5), 4'd1, 32'h1234);
        issue(op_t'(3'd7), 4'd1, 32'h1234);
    endtask

    task automatic test_buffered();
        write_capacity(5'd16);
        for (int i = 0; i < 17; i++)
            issue(OP_SEND_NB, 4'(i), $urandom());
        for (int i = 0; i < 3; i++)
            issue(OP_SEND_B, 4'(i), $urandom());
        write_capacity(5'd31);
        issue(OP_RECV_B, 4'd6, '0);
        write_capacity(5'd2);
        for (int i = 0; i < 20; i++)
            issue(OP_RECV_NB, 4'(i), '0);
        write_capacity(5'd1);
    endtask

    task automatic test_random(int n);
        int k;
        op_t op;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 39)
                write_capacity(5'($urandom_range(0, 6)));
            if (i == n / 2)
                drain();
            k = $urandom_range(0, 99);
            if (k < 30) op = OP_SEND_B;
            else if (k < 45) op = OP_SEND_NB;
            else if (k < 75) op = OP_RECV_B;
            else if (k < 97) op = OP_RECV_NB;
            else op = op_t'(3'($urandom_range(5, 7)));
            issue(op, 4'($urandom()), $urandom(), (i / 20) % 2 == 0);
        end
    endtask

    task automatic test_close();
        write_capacity(5'd2);
        issue(OP_SEND_B, 4'd1, 32'h0000_0011);
        issue(OP_SEND_B, 4'd2, 32'h0000_0022);
        for (int i = 0; i < 8; i++)
            issue(OP_SEND_B, 4'(i + 3), 32'hC000_0000 + i);
        issue(OP_CLOSE, 4'd9, '0);
        issue(OP_SEND_B, 4'd4, 32'h1);
        issue(OP_SEND_NB, 4'd4, 32'h1);
        issue(OP_RECV_NB, 4'd5, '0);
        issue(OP_RECV_B, 4'd5, '0);
        issue(OP_RECV_B, 4'd5, '0);
        issue(OP_CLOSE, 4'd6, '0);
    endtask

    initial begin
        cap_reg = '0;
        fifo_rd = '0;
        fifo_fill = '0;
        chan_closed = 1'b0;
        snd_rd = '0;
        snd_wr = '0;
        rcv_rd = '0;
        rcv_wr = '0;
        snd_cnt = 0;
        rcv_cnt = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_rendezvous();
        test_buffered();
        test_random(90);
        test_close();
        drain();
        if (errors == 0 && pending_cpl.size() == 0)
            $display("** blocking_channel_mailbox_unit: PASSED **");
        else
            $display("** blocking_channel_mailbox_unit: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
